// File: rtl/core/cqs_pkg.sv
// Shared types and codes for the circular queue with search.
// Holds the command and status codes, the controller states and the transfer structs.
// No dependencies.
`timescale 1ns / 1ps

package cqs_pkg;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 7;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [WORD_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] data_out;
        logic                     found;
        logic [OCC_W-1:0]         occupancy;
    } rsp_t;

endpackage

// File: rtl/core/cqs_ram.sv
// Slot storage for the queue: one write port, one read port, registered read data.
// Depends on cqs_pkg for the word width.
`timescale 1ns / 1ps

module cqs_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [ADDR_W-1:0]                 wr_addr,
    input  logic signed [cqs_pkg::WORD_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [ADDR_W-1:0]                 rd_addr,
    output logic signed [cqs_pkg::WORD_W-1:0] rd_data
);

    logic signed [cqs_pkg::WORD_W-1:0] mem [DEPTH];
    logic signed [cqs_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/circular_queue_with_search.sv
// Top level of the circular queue with search: pointers, command sequencer, result register.
// Depends on cqs_pkg and cqs_ram.
//
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   req  (cqs_pkg::req_t)
// result    out        done pulse, one cycle  rsp  (cqs_pkg::rsp_t)
//
// Add, an unused command code, a remove on an empty queue and a search on an empty queue
// keep busy low; the result appears in the next cycle.
// Remove reads the head slot through the slot RAM read port, then gives its result from ST_REMOVE.
// Search pops entries until a match or an empty queue; the RAM read port walks one slot a cycle.
// Reset clears both pointers (empty queue); slot contents are not cleared.
// The receiver cannot stall; each result stays on rsp from the cycle done is high until the next result.
`timescale 1ns / 1ps

module circular_queue_with_search #(
    parameter int DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cqs_pkg::req_t req,
    output logic          done,
    output cqs_pkg::rsp_t rsp
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam int EXT_W = (CNT_W > cqs_pkg::OCC_W) ? CNT_W : cqs_pkg::OCC_W;

    cqs_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] head_inc, tail_inc;

    logic signed [cqs_pkg::WORD_W-1:0] key_reg, key_next;
    logic signed [cqs_pkg::WORD_W-1:0] rd_data;

    logic          done_reg, done_next;
    cqs_pkg::rsp_t rsp_reg, rsp_next;

    logic [1:0]                        status_next;
    logic signed [cqs_pkg::WORD_W-1:0] data_out_next;
    logic                              found_next;

    logic accept, empty, full, match;
    logic wr_en, rd_en;

    logic [CNT_W-1:0] count;
    logic [EXT_W-1:0] count_ext;

    assign busy   = (state_reg != cqs_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign empty    = (head_reg == tail_reg);
    assign full     = (tail_inc == head_reg);
    assign match    = (rd_data == key_reg);

    cqs_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (req.data_in),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cqs_pkg::ST_IDLE:
            begin
                if (accept && !empty)
                begin
                    if (req.cmd == cqs_pkg::CMD_REMOVE)
                    begin
                        state_next = cqs_pkg::ST_REMOVE;
                    end
                    else if (req.cmd == cqs_pkg::CMD_SEARCH)
                    begin
                        state_next = cqs_pkg::ST_SEARCH;
                    end
                end
            end
            cqs_pkg::ST_REMOVE:
            begin
                state_next = cqs_pkg::ST_IDLE;
            end
            cqs_pkg::ST_SEARCH:
            begin
                if (match || empty)
                begin
                    state_next = cqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        key_next      = key_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        done_next     = 1'b0;
        status_next   = cqs_pkg::STAT_OK;
        data_out_next = '0;
        found_next    = 1'b0;
        unique case (state_reg)
            cqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.cmd)
                        cqs_pkg::CMD_ADD:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = cqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                tail_next = tail_inc;
                            end
                        end
                        cqs_pkg::CMD_REMOVE:
                        begin
                            if (empty)
                            begin
                                done_next   = 1'b1;
                                status_next = cqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                rd_en     = 1'b1;
                                head_next = head_inc;
                            end
                        end
                        cqs_pkg::CMD_SEARCH:
                        begin
                            key_next = req.data_in;
                            if (empty)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_en     = 1'b1;
                                head_next = head_inc;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            cqs_pkg::ST_REMOVE:
            begin
                done_next     = 1'b1;
                data_out_next = rd_data;
            end
            cqs_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                end
                else if (empty)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    rd_en     = 1'b1;
                    head_next = head_inc;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // occupancy after the command, from the next pointers
    assign count = (tail_next >= head_next)
                 ? CNT_W'({1'b0, tail_next} - {1'b0, head_next})
                 : CNT_W'({1'b0, tail_next} + CNT_W'(DEPTH) - {1'b0, head_next});
    assign count_ext = EXT_W'(count);
    assign rsp_next  = {status_next, data_out_next, found_next,
                        count_ext[cqs_pkg::OCC_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqs_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (done_next)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: tb/circular_queue_with_search_test.sv
// Self-checking testbench for circular_queue_with_search: directed and random command streams.
// A scoreboard class predicts each result from its own copy of the ring; plain tasks drive commands.
// Depends on cqs_pkg and the circular_queue_with_search RTL.
`timescale 1ns / 1ps

module circular_queue_with_search_test;

    localparam int QDEPTH = 128;
    localparam int RANDOM_ITEMS = 1200;
    localparam int PHASES = 4;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED,
        MODE_HUNT
    } mix_mode_t;

    class queue_scoreboard;
        logic signed [cqs_pkg::WORD_W-1:0] ring [QDEPTH];
        int unsigned     head_idx;
        int unsigned     tail_idx;
        cqs_pkg::rsp_t   pending [$];
        time             pending_at [$];
        int              errors;
        int              reported;
        int              n_add, n_full, n_remove, n_empty, n_search, n_found, n_missed, n_unused;
        int              peak;

        function new();
            head_idx = 0;
            tail_idx = 0;
            errors = 0;
            reported = 0;
            n_add = 0; n_full = 0; n_remove = 0; n_empty = 0;
            n_search = 0; n_found = 0; n_missed = 0; n_unused = 0;
            peak = 0;
        endfunction

        function int unsigned held();
            return (tail_idx + QDEPTH - head_idx) % QDEPTH;
        endfunction

        function logic signed [cqs_pkg::WORD_W-1:0] entry(int unsigned k);
            return ring[(head_idx + k) % QDEPTH];
        endfunction

        function void note_command(cqs_pkg::req_t r);
            cqs_pkg::rsp_t want;
            int unsigned   n;
            want = '0;
            want.status = cqs_pkg::STAT_OK;
            case (r.cmd)
                cqs_pkg::CMD_ADD:
                begin
                    n_add++;
                    if ((tail_idx + 1) % QDEPTH == head_idx)
                    begin
                        want.status = cqs_pkg::STAT_FULL;
                        n_full++;
                    end
                    else
                    begin
                        ring[tail_idx] = r.data_in;
                        tail_idx = (tail_idx + 1) % QDEPTH;
                    end
                end
                cqs_pkg::CMD_REMOVE:
                begin
                    n_remove++;
                    if (head_idx == tail_idx)
                    begin
                        want.status = cqs_pkg::STAT_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        want.data_out = ring[head_idx];
                        head_idx = (head_idx + 1) % QDEPTH;
                    end
                end
                cqs_pkg::CMD_SEARCH:
                begin
                    n_search++;
                    if (head_idx != tail_idx)
                    begin
                        while (!want.found && head_idx != tail_idx)
                        begin
                            if (ring[head_idx] == r.data_in)
                                want.found = 1'b1;
                            head_idx = (head_idx + 1) % QDEPTH;
                        end
                        if (want.found)
                            n_found++;
                        else
                            n_missed++;
                    end
                end
                default: n_unused++;
            endcase
            n = held();
            want.occupancy = n[cqs_pkg::OCC_W-1:0];
            if (n > peak)
                peak = n;
            pending.push_back(want);
            pending_at.push_back($time);
        endfunction

        function void check_result(cqs_pkg::rsp_t got);
            cqs_pkg::rsp_t want;
            if (pending.size() == 0 || pending_at[0] >= $time)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("%0t: result with nothing outstanding:", $time);
                    $display("    status=%0d data_out=%0d found=%0d occupancy=%0d",
                             got.status, got.data_out, got.found, got.occupancy);
                end
                return;
            end
            want = pending.pop_front();
            void'(pending_at.pop_front());
            if (got.status !== want.status || got.data_out !== want.data_out ||
                got.found !== want.found || got.occupancy !== want.occupancy)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("%0t: mismatch", $time);
                    $display("    expected status=%0d data_out=%0d found=%0d occupancy=%0d",
                             want.status, want.data_out, want.found, want.occupancy);
                    $display("    got      status=%0d data_out=%0d found=%0d occupancy=%0d",
                             got.status, got.data_out, got.found, got.occupancy);
                end
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    cqs_pkg::req_t req;
    logic          done;
    cqs_pkg::rsp_t rsp;

    queue_scoreboard sb = new();
    logic signed [cqs_pkg::WORD_W-1:0] value_pool [6] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sd42
    };

    circular_queue_with_search #(
        .DEPTH (QDEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(rsp);
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // hold start across back-to-back transfers; drop it only for idle cycles
    task automatic issue(input logic [1:0] cmd, input logic signed [cqs_pkg::WORD_W-1:0] data,
                         input int idle_pct);
        cqs_pkg::req_t r;
        r.cmd = cmd;
        r.data_in = data;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note_command(r);
    endtask

    function automatic logic signed [cqs_pkg::WORD_W-1:0] pick_value();
        if ($urandom_range(9) < 4)
            return value_pool[$urandom_range(5)];
        return $urandom;
    endfunction

    task automatic issue_random(input mix_mode_t mode, input int idle_pct);
        int roll;
        int unsigned n;
        logic [1:0] cmd;
        logic signed [cqs_pkg::WORD_W-1:0] data;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:  cmd = roll < 88 ? cqs_pkg::CMD_ADD : roll < 93 ? cqs_pkg::CMD_REMOVE :
                              roll < 98 ? cqs_pkg::CMD_SEARCH : CMD_UNUSED;
            MODE_DRAIN: cmd = roll < 15 ? cqs_pkg::CMD_ADD : roll < 85 ? cqs_pkg::CMD_REMOVE :
                              roll < 98 ? cqs_pkg::CMD_SEARCH : CMD_UNUSED;
            MODE_MIXED: cmd = roll < 45 ? cqs_pkg::CMD_ADD : roll < 72 ? cqs_pkg::CMD_REMOVE :
                              roll < 98 ? cqs_pkg::CMD_SEARCH : CMD_UNUSED;
            default:    cmd = roll < 55 ? cqs_pkg::CMD_ADD : roll < 62 ? cqs_pkg::CMD_REMOVE :
                              roll < 98 ? cqs_pkg::CMD_SEARCH : CMD_UNUSED;
        endcase
        n = sb.held();
        if (cmd == cqs_pkg::CMD_SEARCH && n > 0 && $urandom_range(99) < 70)
            data = sb.entry($urandom_range(n - 1));
        else
            data = pick_value();
        issue(cmd, data, idle_pct);
    endtask

    initial
    begin
        int idle_by_phase [PHASES];
        mix_mode_t mode;
        int left_in_mode;

        idle_by_phase = '{0, 45, 28, 0};
        rst_n = 1'b0;
        start <= 1'b0;
        req <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(cqs_pkg::CMD_REMOVE, 32'sd0, 0);
        issue(cqs_pkg::CMD_SEARCH, 32'sd0, 0);
        issue(CMD_UNUSED, 32'sd7, 0);
        issue(cqs_pkg::CMD_ADD, 32'sh7FFFFFFF, 0);
        issue(cqs_pkg::CMD_ADD, 32'sh80000000, 0);
        issue(cqs_pkg::CMD_ADD, 32'sd0, 0);
        issue(cqs_pkg::CMD_ADD, -32'sd1, 0);
        issue(cqs_pkg::CMD_ADD, 32'sd5, 0);
        issue(CMD_UNUSED, -32'sd1, 0);
        issue(cqs_pkg::CMD_REMOVE, 32'sd0, 0);
        issue(cqs_pkg::CMD_SEARCH, -32'sd1, 0);
        issue(cqs_pkg::CMD_SEARCH, 32'sd5, 0);
        issue(cqs_pkg::CMD_ADD, 32'sd1, 0);
        issue(cqs_pkg::CMD_ADD, 32'sd2, 0);
        issue(cqs_pkg::CMD_ADD, 32'sd1, 0);
        issue(cqs_pkg::CMD_SEARCH, 32'sd1, 0);
        issue(cqs_pkg::CMD_SEARCH, 32'sd99, 0);
        issue(cqs_pkg::CMD_REMOVE, 32'sd0, 0);
        issue(cqs_pkg::CMD_ADD, 32'sh80000000, 0);
        issue(cqs_pkg::CMD_SEARCH, 32'sh80000000, 0);
        issue(cqs_pkg::CMD_ADD, 32'sh55555555, 0);
        issue(cqs_pkg::CMD_ADD, 32'shAAAAAAAA, 0);
        issue(cqs_pkg::CMD_REMOVE, 32'sd0, 0);
        issue(cqs_pkg::CMD_REMOVE, 32'sd0, 0);
        issue(cqs_pkg::CMD_REMOVE, 32'sd0, 0);

        mode = MODE_FILL;
        left_in_mode = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
            begin
                if (left_in_mode == 0)
                begin
                    mode = mix_mode_t'($urandom_range(3));
                    left_in_mode = $urandom_range(40, 200);
                end
                left_in_mode--;
                issue_random(mode, idle_by_phase[p]);
            end
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (QDEPTH + 10) @(posedge clk);

        $display("Ran %0d adds (%0d on full), %0d removes (%0d on empty), %0d unused commands.",
                 sb.n_add, sb.n_full, sb.n_remove, sb.n_empty, sb.n_unused);
        $display("Ran %0d searches (%0d matched, %0d emptied the queue); peak occupancy %0d.",
                 sb.n_search, sb.n_found, sb.n_missed, sb.peak);
        $display("%0d errors.", sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
